### hw/rtl/bdq_pkg.sv
// ----------------------------------------------------------------------------
// bdq_pkg
// shared codes and types for the bounded double-ended queue
// ----------------------------------------------------------------------------
package bdq_pkg;

  localparam int REQ_W   = 3;
  localparam int STAT_W  = 3;
  localparam int VALUE_W = 64;
  localparam int CAP_W   = 5;

  localparam logic [REQ_W-1:0] REQ_PUSH_LEFT  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_RIGHT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_POP_LEFT   = 3'd2;
  localparam logic [REQ_W-1:0] REQ_POP_RIGHT  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_CLEAR      = 3'd4;

  localparam logic [STAT_W-1:0] ST_PUSHED_LEFT  = 3'd0;
  localparam logic [STAT_W-1:0] ST_PUSHED_RIGHT = 3'd1;
  localparam logic [STAT_W-1:0] ST_POPPED_LEFT  = 3'd2;
  localparam logic [STAT_W-1:0] ST_POPPED_RIGHT = 3'd3;
  localparam logic [STAT_W-1:0] ST_FULL         = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY        = 3'd5;
  localparam logic [STAT_W-1:0] ST_CLEARED      = 3'd6;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic exec;      // apply the accepted request this cycle
    logic load_ram;  // capture memory read data into the result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
  } sts_t;

endpackage

### hw/rtl/bounded_deque.sv
// ----------------------------------------------------------------------------
// bounded_deque
// double-ended queue of 64-bit signed entries with a programmable capacity
// ----------------------------------------------------------------------------
// Each item is a push at either end, a pop from either end or a clear, and
// gives one result item (unused request codes are taken and give none).
// Pushes, clears, full pushes and empty pops load the result register
// directly; a pop that returns an entry goes via the registered memory read
// port. The capacity register (reset 16) is written via cfg, by the user only
// while idle (not enforced by the block), and its value in use is limited to
// DEPTH. The result register lets the next item enter as its result is taken.
// ----------------------------------------------------------------------------
module bounded_deque
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [STAT_W-1:0]         status,
  output logic signed [VALUE_W-1:0] result_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CAP_W-1:0]          capacity
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  bdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .req_type (req_type),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  bdq_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (capacity),
    .req_type    (req_type),
    .push_value  (push_value),
    .cmd         (cmd),
    .sts         (sts),
    .status      (status),
    .result_value(result_value)
  );

`ifndef ASSERT_OFF
  // memory data lands only when the result register is free
  a_ram_slot_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_ram |-> !out_valid)
    else $error("pop data arrived while result register busy");

  a_push_left_echo: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_PUSH_LEFT && !sts.full) |=>
      (out_valid && status == ST_PUSHED_LEFT && result_value == $past(push_value)))
    else $error("push left result mismatch");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && sts.empty &&
     (req_type == REQ_POP_LEFT || req_type == REQ_POP_RIGHT)) |=>
      (out_valid && status == ST_EMPTY && result_value == '0))
    else $error("pop from empty queue not reported");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && req_type == REQ_CLEAR) |=> sts.empty)
    else $error("queue not empty after clear");
`endif

endmodule

### hw/rtl/bdq_ram.sv
// ----------------------------------------------------------------------------
// bdq_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module bdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/bdq_ctrl.sv
// ----------------------------------------------------------------------------
// bdq_ctrl
// request sequencing and result valid for the bounded double-ended queue
// ----------------------------------------------------------------------------
module bdq_ctrl
  import bdq_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [REQ_W-1:0] req_type,
  output logic             out_valid,
  input  logic             out_stall,
  output cmd_t             cmd,
  input  sts_t             sts
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_READ = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic accept;
  logic direct_result;
  logic wait_read;

  assign in_stall = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  always_comb begin
    direct_result = 1'b0;
    wait_read     = 1'b0;
    unique case (req_type)
      REQ_PUSH_LEFT, REQ_PUSH_RIGHT, REQ_CLEAR: direct_result = 1'b1;
      REQ_POP_LEFT, REQ_POP_RIGHT: begin
        direct_result = sts.empty;
        wait_read     = !sts.empty;
      end
      default: ;
    endcase
  end

  assign cmd.exec     = accept;
  assign cmd.load_ram = (state == S_READ);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && wait_read) begin
          state_next = S_READ;
        end
      end
      S_READ: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    if ((accept && direct_result) || cmd.load_ram) begin
      out_valid_next = 1'b1;
    end else begin
      out_valid_next = out_valid && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

### hw/rtl/bdq_dp.sv
// ----------------------------------------------------------------------------
// bdq_dp
// pointers, entry memory, capacity register and result register
// ----------------------------------------------------------------------------
module bdq_dp
  import bdq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [CAP_W-1:0]          cfg_data,
  input  logic [REQ_W-1:0]          req_type,
  input  logic signed [VALUE_W-1:0] push_value,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  output logic [STAT_W-1:0]         status,
  output logic signed [VALUE_W-1:0] result_value
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);
  localparam int LW   = (CNTW > CAP_W) ? CNTW : CAP_W;
  localparam int SW   = CNTW + 1;
  localparam logic [AW-1:0] LAST_POS = AW'(DEPTH - 1);
  localparam logic [SW-1:0] DEPTH_S  = SW'(DEPTH);
  localparam logic [LW-1:0] DEPTH_L  = LW'(DEPTH);

  logic [CAP_W-1:0]          capacity;
  logic [AW-1:0]             head;
  logic [AW-1:0]             head_next;
  logic [CNTW-1:0]           count;
  logic [CNTW-1:0]           count_next;
  logic [STAT_W-1:0]         pop_status;
  logic [LW-1:0]             cap_l;
  logic [LW-1:0]             limit;
  logic [SW-1:0]             tail_sum;
  logic [SW-1:0]             last_sum;
  logic [AW-1:0]             tail_pos;
  logic [AW-1:0]             last_pos;
  logic [AW-1:0]             head_dec;
  logic [AW-1:0]             head_inc;
  logic                      we;
  logic                      re;
  logic [AW-1:0]             waddr;
  logic [AW-1:0]             raddr;
  logic [VALUE_W-1:0]        rdata;
  logic                      load_direct;
  logic [STAT_W-1:0]         direct_status;
  logic signed [VALUE_W-1:0] direct_value;

  assign cap_l     = LW'(capacity);
  assign limit     = (cap_l > DEPTH_L) ? DEPTH_L : cap_l;
  assign sts.full  = LW'(count) >= limit;
  assign sts.empty = (count == '0);

  // circular positions, each sum stays below twice the depth wherever it is used
  assign tail_sum = SW'(head) + SW'(count);
  assign last_sum = tail_sum - SW'(1);
  assign tail_pos = AW'((tail_sum >= DEPTH_S) ? (tail_sum - DEPTH_S) : tail_sum);
  assign last_pos = AW'((last_sum >= DEPTH_S) ? (last_sum - DEPTH_S) : last_sum);
  assign head_dec = (head == '0) ? LAST_POS : (head - AW'(1));
  assign head_inc = (head == LAST_POS) ? '0 : (head + AW'(1));

  always_comb begin
    head_next     = head;
    count_next    = count;
    we            = 1'b0;
    re            = 1'b0;
    waddr         = tail_pos;
    raddr         = head;
    load_direct   = 1'b0;
    direct_status = ST_CLEARED;
    direct_value  = '0;
    if (cmd.exec) begin
      case (req_type)
        REQ_PUSH_LEFT, REQ_PUSH_RIGHT: begin
          load_direct = 1'b1;
          if (sts.full) begin
            direct_status = ST_FULL;
          end else begin
            we           = 1'b1;
            count_next   = count + CNTW'(1);
            direct_value = push_value;
            if (req_type == REQ_PUSH_LEFT) begin
              waddr         = head_dec;
              head_next     = head_dec;
              direct_status = ST_PUSHED_LEFT;
            end else begin
              waddr         = tail_pos;
              direct_status = ST_PUSHED_RIGHT;
            end
          end
        end
        REQ_POP_LEFT, REQ_POP_RIGHT: begin
          if (sts.empty) begin
            load_direct   = 1'b1;
            direct_status = ST_EMPTY;
          end else begin
            re         = 1'b1;
            count_next = count - CNTW'(1);
            if (req_type == REQ_POP_LEFT) begin
              raddr     = head;
              head_next = head_inc;
            end else begin
              raddr = last_pos;
            end
          end
        end
        REQ_CLEAR: begin
          load_direct   = 1'b1;
          direct_status = ST_CLEARED;
          head_next     = '0;
          count_next    = '0;
        end
        default: ;
      endcase
    end
  end

  bdq_ram #(
    .WIDTH(VALUE_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(push_value),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      head     <= '0;
      count    <= '0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_data;
      end
      head  <= head_next;
      count <= count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (re) begin
      pop_status <= (req_type == REQ_POP_LEFT) ? ST_POPPED_LEFT : ST_POPPED_RIGHT;
    end
    if (load_direct) begin
      status       <= direct_status;
      result_value <= direct_value;
    end else if (cmd.load_ram) begin
      status       <= pop_status;
      result_value <= rdata;
    end
  end

endmodule

### bench/bounded_deque_test.sv
// ----------------------------------------------------------------------------
// bounded_deque_test
// self-checking bench for the bounded double-ended queue
// ----------------------------------------------------------------------------
// Drives push, pop, clear and unused request codes into the block. A predictor
// keeps its own copy of the entries, the head position, the count and the
// capacity, and works out the status and value of each accepted item. Each
// result item taken from the block is compared with the oldest prediction.
// A directed opening covers empty and full queues, extreme values, zero
// capacity, capacity above the depth and capacity lowered below the count.
// Random phases at several capacities follow, with fill and drain runs,
// sender bursts and gaps, receiver stall patterns and long hold-offs.
// ----------------------------------------------------------------------------
module bounded_deque_test;
  import bdq_pkg::*;

  localparam int DEPTH = 16;
  localparam int LIMIT = 400000;
  localparam int PHASE_ITEMS = 75;
  localparam logic signed [VALUE_W-1:0] MOST_NEG = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic signed [VALUE_W-1:0] MOST_POS = {1'b0, {(VALUE_W-1){1'b1}}};

  class deque_scoreboard;
    logic signed [VALUE_W-1:0] slots [DEPTH];
    int head;
    int count;
    logic [CAP_W-1:0] cap;
    logic [STAT_W-1:0] want_status [$];
    logic signed [VALUE_W-1:0] want_value [$];
    int errors;
    int checked;
    int tally [7];

    function new();
      head = 0;
      count = 0;
      cap = CAP_RESET;
      errors = 0;
      checked = 0;
      foreach (tally[i]) tally[i] = 0;
      foreach (slots[i]) slots[i] = '0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      cap = c;
    endfunction

    function int pending();
      return want_status.size();
    endfunction

    function void add(logic [STAT_W-1:0] st, logic signed [VALUE_W-1:0] v);
      want_status = {want_status, st};
      want_value = {want_value, v};
    endfunction

    function void note_request(logic [REQ_W-1:0] req, logic signed [VALUE_W-1:0] v);
      int lim;
      int pos;
      lim = (cap > DEPTH) ? DEPTH : int'(cap);
      case (req)
        REQ_PUSH_LEFT, REQ_PUSH_RIGHT: begin
          if (count >= lim) begin
            add(ST_FULL, '0);
          end else begin
            if (req == REQ_PUSH_LEFT) begin
              head = (head + DEPTH - 1) % DEPTH;
              pos = head;
              add(ST_PUSHED_LEFT, v);
            end else begin
              pos = (head + count) % DEPTH;
              add(ST_PUSHED_RIGHT, v);
            end
            slots[pos] = v;
            count++;
          end
        end
        REQ_POP_LEFT, REQ_POP_RIGHT: begin
          if (count == 0) begin
            add(ST_EMPTY, '0);
          end else begin
            if (req == REQ_POP_LEFT) begin
              add(ST_POPPED_LEFT, slots[head]);
              head = (head + 1) % DEPTH;
            end else begin
              add(ST_POPPED_RIGHT, slots[(head + count - 1) % DEPTH]);
            end
            count--;
          end
        end
        REQ_CLEAR: begin
          head = 0;
          count = 0;
          add(ST_CLEARED, '0);
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [STAT_W-1:0] st, logic signed [VALUE_W-1:0] v);
      logic [STAT_W-1:0] e_st;
      logic signed [VALUE_W-1:0] e_v;
      if (want_status.size() == 0) begin
        $error("result with nothing pending: status %0d result_value %0d", st, v);
        errors++;
        return;
      end
      e_st = want_status[0];
      e_v = want_value[0];
      want_status.delete(0);
      want_value.delete(0);
      checked++;
      if (e_st < 7) tally[e_st]++;
      if (st !== e_st) begin
        $error("status: expected %0d, got %0d", e_st, st);
        errors++;
      end
      if (v !== e_v) begin
        $error("result_value: expected %0d, got %0d", e_v, v);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  logic [REQ_W-1:0] req_type;
  logic signed [VALUE_W-1:0] push_value;
  logic out_valid;
  logic out_stall;
  logic [STAT_W-1:0] status;
  logic signed [VALUE_W-1:0] result_value;
  logic cfg_valid;
  logic cfg_ready;
  logic [CAP_W-1:0] capacity;

  deque_scoreboard sb;
  bit hold_off_request;
  int burst_left;
  int cycles;
  int items_sent;
  int cap_settings;

  bounded_deque #(.DEPTH(DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .req_type(req_type),
    .push_value(push_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .result_value(result_value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .capacity(capacity)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) sb.note_request(req_type, push_value);
      if (out_valid && !out_stall) sb.check_result(status, result_value);
    end
  end

  // receiver stall patterns, with a long hold-off on request
  initial begin
    int mode;
    int span;
    out_stall <= 1'b0;
    wait (rst === 1'b0);
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        @(posedge clk);
        if (hold_off_request) begin
          hold_off_request = 1'b0;
          out_stall <= 1'b1;
          repeat (80) @(posedge clk);
        end else begin
          case (mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            2: out_stall <= ($urandom_range(0, 9) < 7);
            default: out_stall <= ~out_stall;
          endcase
        end
      end
    end
  end

  task automatic send_item(input logic [REQ_W-1:0] r, input logic signed [VALUE_W-1:0] v);
    in_valid <= 1'b1;
    req_type <= r;
    push_value <= v;
    do @(posedge clk); while (in_stall);
    if (r <= REQ_CLEAR) items_sent++;
  endtask

  task automatic offer_item(input logic [REQ_W-1:0] r, input logic signed [VALUE_W-1:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    send_item(r, v);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] c);
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    capacity <= c;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_capacity(c);
    cap_settings++;
  endtask

  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return MOST_NEG;
      1: return MOST_POS;
      2: return '0;
      3: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic random_phase(input logic [CAP_W-1:0] c, input bit with_hold);
    bit filling;
    int run_left;
    int n;
    int roll;
    int push_share;
    logic [REQ_W-1:0] r;
    write_capacity(c);
    filling = 1'b1;
    run_left = $urandom_range(10, 40);
    n = 0;
    while (n < PHASE_ITEMS) begin
      if (run_left == 0) begin
        filling = ~filling;
        run_left = $urandom_range(10, 40);
      end
      run_left--;
      if (with_hold && n == 30) hold_off_request = 1'b1;
      push_share = filling ? 70 : 25;
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        r = REQ_REQ_UNUSED_PICK();
      end else if (roll < 5) begin
        r = REQ_CLEAR;
      end else if (roll < 5 + push_share) begin
        r = $urandom_range(0, 1) ? REQ_PUSH_RIGHT : REQ_PUSH_LEFT;
      end else begin
        r = $urandom_range(0, 1) ? REQ_POP_RIGHT : REQ_POP_LEFT;
      end
      offer_item(r, pick_value());
      if (r <= REQ_CLEAR) n++;
    end
  endtask

  // request codes above clear are taken by the block and give no result
  function automatic logic [REQ_W-1:0] REQ_REQ_UNUSED_PICK();
    return REQ_CLEAR + REQ_W'($urandom_range(1, 3));
  endfunction

  initial begin
    logic [CAP_W-1:0] phase_caps [12];
    sb = new();
    hold_off_request = 1'b0;
    burst_left = 0;
    cycles = 0;
    items_sent = 0;
    cap_settings = 0;
    phase_caps = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd17, 5'd8, 5'd5, 5'd16, 5'd3,
                   5'd12, 5'd1};
    rst <= 1'b1;
    in_valid <= 1'b0;
    req_type <= REQ_PUSH_LEFT;
    push_value <= '0;
    cfg_valid <= 1'b0;
    capacity <= CAP_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // empty queue, extreme values, unused codes, both ends, clear
    send_item(REQ_POP_LEFT, '0);
    send_item(REQ_POP_RIGHT, '0);
    send_item(REQ_PUSH_LEFT, MOST_NEG);
    send_item(REQ_PUSH_RIGHT, MOST_POS);
    send_item(REQ_PUSH_LEFT, '0);
    send_item(REQ_PUSH_RIGHT, '1);
    send_item(REQ_CLEAR + 3'd1, MOST_POS);
    send_item(REQ_CLEAR + 3'd2, '1);
    send_item(REQ_CLEAR + 3'd3, MOST_NEG);
    send_item(REQ_POP_RIGHT, '0);
    send_item(REQ_POP_LEFT, '0);
    send_item(REQ_POP_LEFT, '0);
    send_item(REQ_POP_RIGHT, '0);
    send_item(REQ_POP_LEFT, '0);
    send_item(REQ_PUSH_RIGHT, 64'sd5);
    send_item(REQ_CLEAR, '0);
    send_item(REQ_POP_RIGHT, '0);

    // zero capacity still drains what is held
    send_item(REQ_PUSH_RIGHT, 64'sd11);
    send_item(REQ_PUSH_RIGHT, 64'sd22);
    write_capacity(5'd0);
    send_item(REQ_PUSH_LEFT, 64'sd33);
    send_item(REQ_POP_LEFT, '0);
    send_item(REQ_POP_RIGHT, '0);

    // capacity above depth, then lowered below the count
    write_capacity(5'd31);
    send_item(REQ_PUSH_LEFT, 64'sd1);
    send_item(REQ_PUSH_LEFT, 64'sd2);
    send_item(REQ_PUSH_RIGHT, 64'sd3);
    write_capacity(5'd2);
    send_item(REQ_PUSH_RIGHT, 64'sd4);
    send_item(REQ_POP_LEFT, '0);
    send_item(REQ_PUSH_LEFT, 64'sd5);
    send_item(REQ_POP_RIGHT, '0);
    send_item(REQ_PUSH_LEFT, 64'sd6);

    foreach (phase_caps[i]) random_phase(phase_caps[i], (i == 2) || (i == 8));

    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    $display("%0d requests over %0d capacity settings, %0d results checked",
             items_sent, cap_settings, sb.checked);
    $display("pushes %0d, pops %0d, full %0d, empty %0d, clears %0d",
             sb.tally[ST_PUSHED_LEFT] + sb.tally[ST_PUSHED_RIGHT],
             sb.tally[ST_POPPED_LEFT] + sb.tally[ST_POPPED_RIGHT],
             sb.tally[ST_FULL], sb.tally[ST_EMPTY], sb.tally[ST_CLEARED]);
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
